>>> hw/rtl/itrt_pkg.sv
`default_nettype none

package itrt_pkg;

  // width of the converted integer, 8..64
  localparam int VALUE_WIDTH = 64;

  // divider step counter and digit counter widths
  localparam int STEP_W  = $clog2(VALUE_WIDTH);
  localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [4:0] BASE_MIN     = 5'd2;
  localparam logic [4:0] BASE_MAX     = 5'd16;
  localparam logic [4:0] BASE_DECIMAL = 5'd10;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic        kind;
    logic [63:0] value;
    logic [4:0]  base;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       base_invalid;
  } text_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [3:0]             remainder;
  } div_res_t;

  // digit value to lower-case ascii glyph
  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = 8'h30 + {4'd0, d};
    end else begin
      g = 8'h61 + {4'd0, d} - 8'd10;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itrt_divider.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module itrt_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [itrt_pkg::VALUE_WIDTH-1:0] dividend,
  input  wire logic [4:0]                       divisor,
  output itrt_pkg::div_res_t                    res
);

  logic                             busy;
  logic                             done;
  logic [itrt_pkg::STEP_W-1:0]      step;
  logic [itrt_pkg::VALUE_WIDTH-1:0] dvd;
  logic [3:0]                       rem;
  logic [4:0]                       dsr;

  logic [4:0] trial;
  logic       ge;
  logic [4:0] diff;

  always_comb begin
    trial = {rem, dvd[itrt_pkg::VALUE_WIDTH-1]};
    ge    = (trial >= dsr);
    diff  = trial - dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        rem  <= 4'd0;
        dsr  <= divisor;
      end else if (busy) begin
        dvd  <= {dvd[itrt_pkg::VALUE_WIDTH-2:0], ge};
        rem  <= ge ? diff[3:0] : trial[3:0];
        step <= step + 1'b1;
        if (step == itrt_pkg::STEP_W'(itrt_pkg::VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = dvd;
  assign res.remainder = rem;

endmodule

`default_nettype wire

>>> hw/rtl/integer_to_radix_text_unit.sv
`default_nettype none

// integer to ascii text in radix 2..16. each input transaction carries a
// signedness mode, a value (low VALUE_WIDTH bits used) and a base; the unit
// returns one output transaction per character, most significant digit first,
// lower-case a-f above 9, last set on the final character. a negative signed
// value is converted by its magnitude and gets a leading '-' in base 10 only.
// a base outside 2..16 gives a single transaction with character 0, last and
// base_invalid set. digits are produced least significant first by a
// shared bit-serial divider, then drained from the digit stack at one
// character per cycle while text_stall is low. item_stall is high
// during reset and from acceptance until the last character has entered the
// output register; that register lets the next item in while the last
// character still waits on text_stall.
module integer_to_radix_text_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_stall,
  input  wire itrt_pkg::item_t item,
  output      logic            text_valid,
  input  wire logic            text_stall,
  output      itrt_pkg::text_t text
);

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    INVALID,
    SIGN,
    DIGITS
  } state_t;

  state_t state;

  // latched per-transaction context
  logic [4:0]                   base;
  logic                         negative;
  logic [itrt_pkg::COUNT_W-1:0] count;

  // digit stack, newest digit at the top
  logic [3:0] stack [itrt_pkg::VALUE_WIDTH];

  // divider hookup
  logic                             div_start;
  logic [itrt_pkg::VALUE_WIDTH-1:0] div_dividend;
  logic [4:0]                       div_divisor;
  itrt_pkg::div_res_t               div_res;

  logic [itrt_pkg::VALUE_WIDTH-1:0] raw;
  logic                             raw_negative;
  logic [itrt_pkg::VALUE_WIDTH-1:0] magnitude;
  logic                             accept;
  logic                             base_ok;
  logic                             can_load;
  logic                             emit;
  logic                             more_digits;

  assign item_stall = rst || (state != IDLE);

  always_comb begin
    raw          = item.value[itrt_pkg::VALUE_WIDTH-1:0];
    raw_negative = item.kind & raw[itrt_pkg::VALUE_WIDTH-1];
    magnitude    = raw_negative ? (~raw + 1'b1) : raw;
    base_ok      = item.base inside {[itrt_pkg::BASE_MIN:itrt_pkg::BASE_MAX]};
    accept       = item_valid && !item_stall;
    can_load     = !text_valid || !text_stall;
    emit         = can_load && (state inside {INVALID, SIGN, DIGITS});
    more_digits  = (div_res.quotient != '0);
  end

  // start on an accepted item with a legal base, and again on each quotient that is still nonzero
  always_comb begin
    div_start    = 1'b0;
    div_dividend = magnitude;
    div_divisor  = base;
    if (accept && base_ok) begin
      div_start   = 1'b1;
      // base register loads on this same edge, so pass the incoming base through
      div_divisor = item.base;
    end else if ((state == DIVIDE) && div_res.done && more_digits) begin
      div_start    = 1'b1;
      div_dividend = div_res.quotient;
    end
  end

  itrt_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      text_valid <= 1'b0;
      count      <= '0;
    end else begin
      // a new character loads, otherwise the held one stays until taken
      text_valid <= emit || (text_valid && text_stall);
      case (state)
        IDLE: begin
          if (accept) begin
            base     <= item.base;
            negative <= raw_negative;
            count    <= '0;
            state    <= base_ok ? DIVIDE : INVALID;
          end
        end
        DIVIDE: begin
          if (div_res.done) begin
            for (int i = itrt_pkg::VALUE_WIDTH - 1; i > 0; i--) begin
              stack[i] <= stack[i-1];
            end
            stack[0] <= div_res.remainder;
            count    <= count + 1'b1;
            if (!more_digits) begin
              state <= (negative && (base == itrt_pkg::BASE_DECIMAL)) ? SIGN : DIGITS;
            end
          end
        end
        INVALID: begin
          if (can_load) begin
            text.character    <= itrt_pkg::CHAR_NONE;
            text.last         <= 1'b1;
            text.base_invalid <= 1'b1;
            state             <= IDLE;
          end
        end
        SIGN: begin
          if (can_load) begin
            text.character    <= itrt_pkg::CHAR_MINUS;
            text.last         <= 1'b0;
            text.base_invalid <= 1'b0;
            state             <= DIGITS;
          end
        end
        DIGITS: begin
          if (can_load) begin
            text.character    <= itrt_pkg::digit_glyph(stack[0]);
            text.last         <= (count == itrt_pkg::COUNT_W'(1));
            text.base_invalid <= 1'b0;
            for (int i = 0; i < itrt_pkg::VALUE_WIDTH - 1; i++) begin
              stack[i] <= stack[i+1];
            end
            count <= count - 1'b1;
            if (count == itrt_pkg::COUNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // digit glyphs, most significant byte holds digit value 0
  localparam logic [127:0] GLYPHS = "0123456789abcdef";
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 260;
  // random items in the window where the receiver holds off
  localparam int PRESSURE_FIRST = 100;
  localparam int PRESSURE_LAST = 109;
  localparam int HOLD_OFF_CYCLES = 3000;
  // final stretch of the run with neither side idling
  localparam int QUIET_TAIL = 40;
  // one full 64-digit conversion plus its stack drain, with margin
  localparam int DRAIN_CYCLES = 4400;

  // expected text for every accepted conversion, checked in arrival order
  class radix_text_board;
    itrt_pkg::text_t expected_chars[$];
    int    errors;
    int    conversions;
    int    invalid_bases;
    int    signed_decimals;
    int    chars_checked;

    function new();
      errors = 0;
      conversions = 0;
      invalid_bases = 0;
      signed_decimals = 0;
      chars_checked = 0;
    endfunction

    // work out the characters one accepted transaction must produce
    function void add_conversion(itrt_pkg::item_t it);
      logic [63:0]     mask;
      logic [63:0]     raw;
      logic [63:0]     mag;
      logic [63:0]     radix;
      logic [3:0]      rem;
      logic            neg;
      logic [7:0]      digits[$];
      itrt_pkg::text_t t;
      conversions++;
      if (it.base < itrt_pkg::BASE_MIN || it.base > itrt_pkg::BASE_MAX) begin
        t.character = itrt_pkg::CHAR_NONE;
        t.last = 1'b1;
        t.base_invalid = 1'b1;
        expected_chars.push_back(t);
        invalid_bases++;
        return;
      end
      mask = {64{1'b1}} >> (64 - itrt_pkg::VALUE_WIDTH);
      raw = it.value & mask;
      neg = it.kind && raw[itrt_pkg::VALUE_WIDTH-1];
      mag = neg ? ((64'd0 - raw) & mask) : raw;
      radix = 64'(it.base);
      // peel off digits least significant first, stack them msd first
      do begin
        rem = 4'(mag % radix);
        digits.push_front(GLYPHS[(15 - rem) * 8 +: 8]);
        mag = mag / radix;
      end while (mag != 64'd0);
      t.base_invalid = 1'b0;
      if (neg && it.base == itrt_pkg::BASE_DECIMAL) begin
        t.character = itrt_pkg::CHAR_MINUS;
        t.last = 1'b0;
        expected_chars.push_back(t);
        signed_decimals++;
      end
      foreach (digits[i]) begin
        t.character = digits[i];
        t.last = (i == digits.size() - 1);
        expected_chars.push_back(t);
      end
    endfunction

    // compare one accepted output transaction with the oldest expectation
    function void check_char(itrt_pkg::text_t got);
      itrt_pkg::text_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected text: char %h last %b invalid %b with nothing pending",
                   got.character, got.last, got.base_invalid);
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.character !== want.character || got.last !== want.last ||
          got.base_invalid !== want.base_invalid) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("text mismatch: want char %h last %b invalid %b, %s %h last %b invalid %b",
                   want.character, want.last, want.base_invalid, "got char",
                   got.character, got.last, got.base_invalid);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  itrt_pkg::item_t item = '0;
  logic            text_valid;
  logic            text_stall = 1'b0;
  itrt_pkg::text_t text;

  // side controls shared between the driving processes
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_off_request = 1'b0;

  radix_text_board board = new();

  integer_to_radix_text_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic itrt_pkg::item_t conv(logic kind, logic [63:0] value, logic [4:0] base);
    itrt_pkg::item_t it;
    it.kind = kind;
    it.value = value;
    it.base = base;
    return it;
  endfunction

  // random conversion: magnitudes of random bit length, some of them full-width,
  // small negatives in signed mode, some bad bases
  function automatic itrt_pkg::item_t random_item();
    itrt_pkg::item_t it;
    int              len;
    int              pick;
    it.kind = 1'($urandom_range(0, 1));
    it.value = {$urandom, $urandom};
    len = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 64);
    if (len < 64)
      it.value = it.value & ((64'd1 << len) - 64'd1);
    if (it.kind && $urandom_range(0, 2) == 0)
      it.value = 64'd0 - it.value;
    if ($urandom_range(0, 6) == 0) begin
      // 0, 1 or 17..31
      pick = $urandom_range(0, 16);
      it.base = 5'((pick < 2) ? pick : pick + 15);
    end else begin
      it.base = 5'($urandom_range(2, 16));
    end
    return it;
  endfunction

  // offer one transaction, optionally after an idle burst, and hold it until taken
  task automatic send_item(itrt_pkg::item_t it);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.add_conversion(it);
  endtask

  // receiving side: check every accepted character, stall in bursts,
  // and one long hold-off when asked so the unit backs up into its input
  initial begin
    int burst;
    int long_hold;
    burst = 0;
    long_hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && text_valid && !text_stall)
        board.check_char(text);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        long_hold = HOLD_OFF_CYCLES;
      end
      if (long_hold > 0) begin
        long_hold--;
        text_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        text_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 11) - 1;
        text_stall <= 1'b1;
      end else begin
        text_stall <= 1'b0;
      end
    end
  end

  initial begin
    itrt_pkg::item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, extremes of each mode, letters, odd bases, bad bases
    send_item(conv(1'b0, 64'd0, 5'd10));
    send_item(conv(1'b0, {64{1'b1}}, 5'd2));
    send_item(conv(1'b0, {64{1'b1}}, 5'd16));
    send_item(conv(1'b0, {64{1'b1}}, itrt_pkg::BASE_DECIMAL));
    // most negative signed value converts through its magnitude
    send_item(conv(1'b1, 64'h8000_0000_0000_0000, itrt_pkg::BASE_DECIMAL));
    send_item(conv(1'b1, 64'h8000_0000_0000_0000, 5'd2));
    send_item(conv(1'b1, {64{1'b1}}, itrt_pkg::BASE_DECIMAL));
    // negative outside base 10: magnitude digits with no sign
    send_item(conv(1'b1, {64{1'b1}}, 5'd16));
    send_item(conv(1'b1, 64'h7fff_ffff_ffff_ffff, itrt_pkg::BASE_DECIMAL));
    send_item(conv(1'b1, 64'd0, 5'd16));
    send_item(conv(1'b0, 64'hfedc_ba98_7654_3210, 5'd16));
    send_item(conv(1'b1, 64'hfedc_ba98_7654_3210, 5'd8));
    send_item(conv(1'b0, 64'd12345, 5'd3));
    // top bit set but unsigned mode: no sign
    send_item(conv(1'b0, 64'h8000_0000_0000_0000, itrt_pkg::BASE_DECIMAL));
    // invalid bases below and above the legal range
    send_item(conv(1'b0, 64'd77, 5'd0));
    send_item(conv(1'b1, {64{1'b1}}, 5'd1));
    send_item(conv(1'b0, 64'd5, 5'd17));
    send_item(conv(1'b1, 64'h8000_0000_0000_0000, 5'd31));
    send_item(conv(1'b0, 64'd255, 5'd15));
    send_item(conv(1'b0, 64'd2024, 5'd13));
    send_item(conv(1'b1, 64'd0 - 64'd1000, 5'd7));
    send_item(conv(1'b1, 64'd0 - 64'd1000, itrt_pkg::BASE_DECIMAL));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_TAIL) begin
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
      end
      if (i >= PRESSURE_FIRST && i <= PRESSURE_LAST) begin
        // short hex conversions back to back while the receiver holds off
        if (i == PRESSURE_FIRST) begin
          hold_off_request = 1'b1;
          sender_gaps = 1'b0;
        end
        it = conv(1'($urandom_range(0, 1)), 64'($urandom_range(0, 65535)), 5'd16);
        send_item(it);
        if (i == PRESSURE_LAST)
          sender_gaps = 1'b1;
      end else begin
        send_item(random_item());
      end
    end
    item_valid <= 1'b0;

    // drain, then watch for stray characters
    while (board.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.errors += board.expected_chars.size();

    $display("covered %0d conversions: %0d with a bad base, %0d negative decimals",
             board.conversions, board.invalid_bases, board.signed_decimals);
    $display("%0d characters compared, %0d failures", board.chars_checked, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
